[hdl/absm_pkg.sv]
// shared constants, codes and interface types of the ambient brightness smoother
`default_nettype none
package absm_pkg;

	localparam int WINDOW_MAX  = 16;
	localparam int SAMPLE_BITS = 16;

	localparam int LEVEL_W    = 16;
	localparam int PCT_W      = 7;
	localparam int WIN_CFG_W  = 5;
	localparam int BRIGHT_W   = 17;
	localparam int CFG_W      = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int FRAC_BITS  = 16;
	localparam int PCT_FULL   = 100;
	localparam int PCT_TWICE  = 2 * PCT_FULL;
	localparam int FULL_Q16   = 65536;

	localparam int IDX_W   = $clog2(WINDOW_MAX);
	localparam int CNT_W   = $clog2(WINDOW_MAX + 1);
	localparam int SUM_W   = $clog2(PCT_FULL * WINDOW_MAX + 1);
	localparam int CMP_W   = (SAMPLE_BITS > LEVEL_W) ? SAMPLE_BITS : LEVEL_W;
	localparam int WCMP_W  = (CNT_W > WIN_CFG_W) ? CNT_W : WIN_CFG_W;
	localparam int NUM1_W  = LEVEL_W + 8;
	localparam int DEN1_W  = LEVEL_W + 1;
	localparam int NUM2_W  = SUM_W + FRAC_BITS;
	localparam int NUM_W   = (NUM1_W > NUM2_W) ? NUM1_W : NUM2_W;
	localparam int DEN_W   = (DEN1_W > SUM_W) ? DEN1_W : SUM_W;
	localparam int STEP_W  = $clog2(NUM_W + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLE = 3'd0,
		REG_LOW    = 3'd1,
		REG_HIGH   = 3'd2,
		REG_FLOOR  = 3'd3,
		REG_WINDOW = 3'd4
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLAMP,
		ST_NUMER,
		ST_DIV1,
		ST_FLOOR,
		ST_HIST,
		ST_SUM,
		ST_DIVB,
		ST_DIV2,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [NUM_W-1:0] quot;
	} div_rsp_t;

	typedef struct packed {
		logic             start;
		logic [PCT_W-1:0] pct;
		logic [CNT_W-1:0] win;
	} hist_req_t;

	typedef struct packed {
		logic             done;
		logic [SUM_W-1:0] sum;
		logic [CNT_W-1:0] count;
	} hist_rsp_t;

endpackage
`default_nettype wire

[hdl/absm_ram.sv]
// generic single write port ram with registered read
`default_nettype none
module absm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

[hdl/absm_div.sv]
// bit-serial restoring divider, one quotient bit per cycle
`default_nettype none
module absm_div
	import absm_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [NUM_W-1:0]  num_q;
	logic [NUM_W-1:0]  quot_q;
	logic [DEN_W-1:0]  den_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W:0]    trial;
	logic [DEN_W:0]    diff;
	logic              ge;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(NUM_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q  <= {num_q[NUM_W-2:0], 1'b0};
			quot_q <= {quot_q[NUM_W-2:0], ge};
			rem_q  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule
`default_nettype wire

[hdl/absm_hist.sv]
// reading history: ring store, fill count and serial window sum
`default_nettype none
module absm_hist
	import absm_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire hist_req_t req,
	output hist_rsp_t      rsp
);

	logic [IDX_W-1:0] newest_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] rd_left_q;
	logic [IDX_W-1:0] rd_addr_q;
	logic             busy_q;
	logic             pend_q;
	logic             done_q;
	logic [SUM_W-1:0] sum_q;
	logic [IDX_W-1:0] next_slot;
	logic [CNT_W-1:0] next_count;
	logic [IDX_W-1:0] prev_addr;
	logic [PCT_W-1:0] rd_data;

	assign next_slot  = (newest_q == IDX_W'(WINDOW_MAX - 1)) ? '0 : newest_q + 1'b1;
	assign next_count = (count_q >= req.win) ? req.win : count_q + 1'b1;
	assign prev_addr  = (rd_addr_q == '0) ? IDX_W'(WINDOW_MAX - 1) : rd_addr_q - 1'b1;

	absm_ram #(
		.WIDTH(PCT_W),
		.DEPTH(WINDOW_MAX)
	) u_ram (
		.clk  (clk),
		.we   (req.start),
		.waddr(next_slot),
		.wdata(req.pct),
		.raddr(rd_addr_q),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			newest_q  <= '0;
			count_q   <= '0;
			rd_left_q <= '0;
			rd_addr_q <= '0;
			busy_q    <= 1'b0;
			pend_q    <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				newest_q  <= next_slot;
				count_q   <= next_count;
				rd_left_q <= next_count;
				rd_addr_q <= next_slot;
				busy_q    <= 1'b1;
				pend_q    <= 1'b0;
			end else if (busy_q) begin
				if (rd_left_q != '0) begin
					rd_addr_q <= prev_addr;
					rd_left_q <= rd_left_q - 1'b1;
					pend_q    <= 1'b1;
				end else begin
					pend_q <= 1'b0;
					if (!pend_q) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			sum_q <= '0;
		end else if (busy_q && pend_q) begin
			sum_q <= sum_q + SUM_W'(rd_data);
		end
	end

	assign rsp.done  = done_q;
	assign rsp.sum   = sum_q;
	assign rsp.count = count_q;

endmodule
`default_nettype wire

[hdl/ambient_brightness_smoother_core.sv]
// top level: config registers, sequencer and scaling datapath
//
//   channel   signals                               direction
//   input     in_valid, in_ready, sensor_sample     sample beat in
//   output    out_valid, out_ready, brightness,     result beat out
//             scaled_percent
//   config    cfg_write, cfg_index, cfg_data        register write, no wait
//
// one sample at a time; a beat is made of two passes of the 27-step serial divider
// with the history sum between them
// disabled beats skip the history pass and the second divide
// an empty range skips the first divide
// a new sample is taken while the previous result waits in the output register
// reset clears the sequencer, history pointers and config to their defaults
`default_nettype none
module ambient_brightness_smoother_core
	import absm_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [SAMPLE_BITS-1:0] sensor_sample,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic      [BRIGHT_W-1:0]    brightness,
	output logic      [PCT_W-1:0]       scaled_percent,
	input  wire logic                   cfg_write,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_W-1:0]       cfg_data
);

	state_t state_q;
	state_t state_d;

	logic                 enable_q;
	logic [LEVEL_W-1:0]   low_q;
	logic [LEVEL_W-1:0]   high_q;
	logic [PCT_W-1:0]     floor_q;
	logic [WIN_CFG_W-1:0] window_q;

	logic [SAMPLE_BITS-1:0] samp_q;
	logic [LEVEL_W-1:0]     d_q;
	logic [LEVEL_W-1:0]     span_q;
	logic                   range_ok_q;
	logic [PCT_W-1:0]       raw_pct_q;
	logic [PCT_W-1:0]       pct_q;
	logic [SUM_W-1:0]       sum_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [BRIGHT_W-1:0]    bright_q;
	logic [BRIGHT_W-1:0]    brightness_q;
	logic [PCT_W-1:0]       scaled_q;
	logic                   out_valid_q;

	logic [CMP_W-1:0]  v_c;
	logic [CMP_W-1:0]  lo_c;
	logic [CMP_W-1:0]  hi_c;
	logic [CMP_W-1:0]  vc_c;
	logic [PCT_W-1:0]  fl_c;
	logic [PCT_W-1:0]  pct_c;
	logic [WCMP_W-1:0] w_ext;
	logic [CNT_W-1:0]  w_c;
	logic              win_gt1;
	logic              out_load;

	div_req_t  div_req;
	div_rsp_t  div_rsp;
	hist_req_t hist_req;
	hist_rsp_t hist_rsp;

	absm_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	absm_hist u_hist (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (hist_req),
		.rsp   (hist_rsp)
	);

	// clamp, floor and window limit
	assign v_c   = CMP_W'(samp_q);
	assign lo_c  = CMP_W'(low_q);
	assign hi_c  = CMP_W'(high_q);
	assign vc_c  = (v_c < lo_c) ? lo_c : ((v_c > hi_c) ? hi_c : v_c);
	assign fl_c  = (floor_q > PCT_W'(PCT_FULL)) ? PCT_W'(PCT_FULL) : floor_q;
	assign pct_c = (raw_pct_q < fl_c) ? fl_c : raw_pct_q;
	assign w_ext = (WCMP_W'(window_q) > WCMP_W'(WINDOW_MAX)) ?
		WCMP_W'(WINDOW_MAX) : WCMP_W'(window_q);
	assign w_c     = CNT_W'(w_ext);
	assign win_gt1 = w_ext > WCMP_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			low_q    <= '0;
			high_q   <= LEVEL_W'(4095);
			floor_q  <= PCT_W'(10);
			window_q <= WIN_CFG_W'(1);
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ENABLE: enable_q <= cfg_data[0];
				REG_LOW:    low_q    <= cfg_data[LEVEL_W-1:0];
				REG_HIGH:   high_q   <= cfg_data[LEVEL_W-1:0];
				REG_FLOOR:  floor_q  <= cfg_data[PCT_W-1:0];
				REG_WINDOW: window_q <= cfg_data[WIN_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_CLAMP;
			end
			ST_CLAMP: state_d = ST_NUMER;
			ST_NUMER: state_d = range_ok_q ? ST_DIV1 : ST_FLOOR;
			ST_DIV1: begin
				if (div_rsp.done) state_d = ST_FLOOR;
			end
			ST_FLOOR: begin
				if (!enable_q) state_d = ST_OUT;
				else if (win_gt1) state_d = ST_HIST;
				else state_d = ST_DIVB;
			end
			ST_HIST: state_d = ST_SUM;
			ST_SUM: begin
				if (hist_rsp.done) state_d = ST_DIVB;
			end
			ST_DIVB: state_d = ST_DIV2;
			ST_DIV2: begin
				if (div_rsp.done) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready      = state_q == ST_IDLE;
		out_load      = (state_q == ST_OUT) && (!out_valid_q || out_ready);
		div_req.start = 1'b0;
		div_req.num   = '0;
		div_req.den   = '0;
		hist_req.start = state_q == ST_HIST;
		hist_req.pct   = pct_q;
		hist_req.win   = w_c;
		unique case (state_q)
			ST_NUMER: begin
				div_req.start = range_ok_q;
				div_req.num   = NUM_W'(NUM1_W'(d_q) * NUM1_W'(PCT_TWICE) + NUM1_W'(span_q));
				div_req.den   = DEN_W'({span_q, 1'b0});
			end
			ST_DIVB: begin
				div_req.start = 1'b1;
				div_req.num   = NUM_W'({sum_q, {FRAC_BITS{1'b0}}});
				div_req.den   = DEN_W'(DEN_W'(cnt_q) * DEN_W'(PCT_FULL));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			samp_q <= sensor_sample;
		end
		case (state_q)
			ST_CLAMP: begin
				d_q        <= LEVEL_W'(vc_c - lo_c);
				span_q     <= high_q - low_q;
				range_ok_q <= high_q > low_q;
			end
			ST_NUMER: begin
				if (!range_ok_q) raw_pct_q <= '0;
			end
			ST_DIV1: begin
				if (div_rsp.done) raw_pct_q <= div_rsp.quot[PCT_W-1:0];
			end
			ST_FLOOR: begin
				pct_q    <= pct_c;
				sum_q    <= SUM_W'(pct_c);
				cnt_q    <= CNT_W'(1);
				bright_q <= BRIGHT_W'(FULL_Q16);
			end
			ST_SUM: begin
				if (hist_rsp.done) begin
					sum_q <= hist_rsp.sum;
					cnt_q <= hist_rsp.count;
				end
			end
			ST_DIV2: begin
				if (div_rsp.done) bright_q <= div_rsp.quot[BRIGHT_W-1:0];
			end
			default: ;
		endcase
		if (out_load) begin
			brightness_q <= bright_q;
			scaled_q     <= pct_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign brightness     = brightness_q;
	assign scaled_percent = scaled_q;

endmodule
`default_nettype wire

[hdl/absm_checker.sv]
// port-level checks on the smoother top level, bound to it
`default_nettype none
module absm_checker
	import absm_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   in_valid,
	input wire logic                   in_ready,
	input wire logic [SAMPLE_BITS-1:0] sensor_sample,
	input wire logic                   out_valid,
	input wire logic                   out_ready,
	input wire logic [BRIGHT_W-1:0]    brightness,
	input wire logic [PCT_W-1:0]       scaled_percent,
	input wire logic                   cfg_write,
	input wire logic [CFG_IDX_W-1:0]   cfg_index,
	input wire logic [CFG_W-1:0]       cfg_data
);

	// one sample in flight: no beat right after an accepted one
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken twice in a row");

	a_reset_state: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> (!out_valid && in_ready))
		else $error("not idle after reset");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
			(out_valid && $stable(brightness) && $stable(scaled_percent)))
		else $error("stalled result changed");

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (brightness <= BRIGHT_W'(FULL_Q16) &&
			scaled_percent <= PCT_W'(PCT_FULL)))
		else $error("result out of range");

endmodule

bind ambient_brightness_smoother_core absm_checker u_absm_checker (.*);
`default_nettype wire

[test/brightness_checker.sv]
// watches the smoother's channels and register writes, predicts each result and compares
`timescale 1ns / 1ps
module brightness_checker
	import absm_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_ready,
	input  logic [SAMPLE_BITS-1:0] sensor_sample,
	input  logic                   out_valid,
	input  logic                   out_ready,
	input  logic [BRIGHT_W-1:0]    brightness,
	input  logic [PCT_W-1:0]       scaled_percent,
	input  logic                   cfg_write,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]       cfg_data,
	output int                     outstanding,
	output int                     fail_count
);

	typedef struct {
		logic [BRIGHT_W-1:0] level;
		logic [PCT_W-1:0]    pct;
	} light_result_t;

	light_result_t    awaited_results[$];
	logic [PCT_W-1:0] readings [WINDOW_MAX];
	int               reading_count;
	int               newest;

	logic                 auto_on;
	logic [LEVEL_W-1:0]   low_level;
	logic [LEVEL_W-1:0]   high_level;
	logic [PCT_W-1:0]     floor_pct;
	logic [WIN_CFG_W-1:0] window_cfg;

	function automatic logic [PCT_W-1:0] scale_reading(input logic [SAMPLE_BITS-1:0] raw);
		longint unsigned v, lo, hi, span, s, fl;
		v = raw;
		lo = low_level;
		hi = high_level;
		s = 0;
		if (hi > lo) begin
			span = hi - lo;
			if (v < lo) v = lo;
			if (v > hi) v = hi;
			s = (PCT_TWICE * (v - lo) + span) / (2 * span);
		end
		fl = (floor_pct > PCT_FULL) ? PCT_FULL : floor_pct;
		if (s < fl) s = fl;
		return PCT_W'(s);
	endfunction

	// updates the reading history as a side effect when enabled with a window above one
	function automatic light_result_t predict_light(input logic [SAMPLE_BITS-1:0] raw);
		light_result_t   r;
		longint unsigned total;
		int              w;
		int              slot;
		r.pct = scale_reading(raw);
		if (!auto_on) begin
			r.level = BRIGHT_W'(FULL_Q16);
		end else begin
			w = (window_cfg > WINDOW_MAX) ? WINDOW_MAX : int'(window_cfg);
			if (w > 1) begin
				if (reading_count > w) reading_count = w;
				if (reading_count == w) reading_count--;
				newest = (newest + 1) % WINDOW_MAX;
				readings[newest] = r.pct;
				reading_count++;
				total = 0;
				slot = newest;
				for (int i = 0; i < reading_count; i++) begin
					total += readings[slot];
					slot = (slot + WINDOW_MAX - 1) % WINDOW_MAX;
				end
				r.level = BRIGHT_W'((total * FULL_Q16) / (PCT_FULL * reading_count));
			end else begin
				total = r.pct;
				r.level = BRIGHT_W'((total * FULL_Q16) / PCT_FULL);
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		light_result_t due;
		if (!arst_n) begin
			auto_on = 1'b0;
			low_level = '0;
			high_level = 16'd4095;
			floor_pct = 7'd10;
			window_cfg = 5'd1;
			reading_count = 0;
			newest = 0;
			foreach (readings[i]) readings[i] = '0;
			awaited_results.delete();
			fail_count = 0;
			outstanding <= 0;
		end else begin
			if (cfg_write) begin
				case (cfg_reg_t'(cfg_index))
					REG_ENABLE: auto_on = cfg_data[0];
					REG_LOW:    low_level = cfg_data[LEVEL_W-1:0];
					REG_HIGH:   high_level = cfg_data[LEVEL_W-1:0];
					REG_FLOOR:  floor_pct = cfg_data[PCT_W-1:0];
					REG_WINDOW: window_cfg = cfg_data[WIN_CFG_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					$error("result beat with nothing expected: brightness %0d, scaled_percent %0d",
						brightness, scaled_percent);
					fail_count++;
				end else begin
					due = awaited_results.pop_front();
					if (brightness !== due.level) begin
						$error("brightness: expected %0d, got %0d", due.level, brightness);
						fail_count++;
					end
					if (scaled_percent !== due.pct) begin
						$error("scaled_percent: expected %0d, got %0d", due.pct, scaled_percent);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready)
				awaited_results.push_back(predict_light(sensor_sample));
			outstanding <= awaited_results.size();
		end
	end

endmodule

[test/tb.sv]
// testbench top: drives samples, register writes and output stalls, and gives the verdict
`timescale 1ns / 1ps
module tb;
	import absm_pkg::*;

	localparam int STALL_LIMIT  = 4000;
	localparam int HOLD_CYCLES  = 400;
	localparam int RANDOM_ITEMS = 1000;
	localparam int QUIET_ITEMS  = 150;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	logic [SAMPLE_BITS-1:0] sensor_sample;
	logic                   out_valid;
	logic                   out_ready;
	logic [BRIGHT_W-1:0]    brightness;
	logic [PCT_W-1:0]       scaled_percent;
	logic                   cfg_write;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_W-1:0]       cfg_data;
	int                     outstanding;
	int                     fail_count;

	bit                 tx_gaps = 1'b0;
	bit                 rx_gaps = 1'b0;
	bit                 hold_request = 1'b0;
	int                 stall_cycles = 0;
	logic [LEVEL_W-1:0] range_low = '0;
	logic [LEVEL_W-1:0] range_high = 16'd4095;

	ambient_brightness_smoother_core uut (.*);

	brightness_checker monitor (.*);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("tb: errors");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	initial begin
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	task automatic send_sample(input logic [SAMPLE_BITS-1:0] value);
		if (tx_gaps && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid <= 1'b1;
		sensor_sample <= value;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	// unused upper data bits must be ignored
	function automatic logic [CFG_W-1:0] with_junk(input logic [CFG_W-1:0] value,
		input logic [CFG_W-1:0] used);
		if ($urandom_range(0, 1) == 1)
			return value | (CFG_W'($urandom) & ~used);
		return value;
	endfunction

	task automatic configure(input bit en, input logic [LEVEL_W-1:0] lo,
		input logic [LEVEL_W-1:0] hi, input logic [PCT_W-1:0] fl,
		input logic [WIN_CFG_W-1:0] win);
		range_low = lo;
		range_high = hi;
		write_reg(REG_ENABLE, with_junk(CFG_W'(en), 16'h0001));
		write_reg(REG_LOW, lo);
		write_reg(REG_HIGH, hi);
		write_reg(REG_FLOOR, with_junk(CFG_W'(fl), 16'h007F));
		write_reg(REG_WINDOW, with_junk(CFG_W'(win), 16'h001F));
	endtask

	task automatic choose_setting();
		bit                   en;
		logic [LEVEL_W-1:0]   a, b;
		logic [PCT_W-1:0]     fl;
		logic [WIN_CFG_W-1:0] win;
		en = ($urandom_range(0, 7) != 0);
		a = $urandom;
		b = $urandom;
		case ($urandom_range(0, 5))
			0: begin
				a = '0;
				b = 16'hFFFF;
			end
			1: b = a;
			2: if (a < b) {a, b} = {b, a};
			3: b = (a > 16'hFFFC) ? 16'hFFFF : a + LEVEL_W'($urandom_range(1, 3));
			default: if (a > b) {a, b} = {b, a};
		endcase
		case ($urandom_range(0, 3))
			0: fl = '0;
			1: fl = PCT_W'(PCT_FULL);
			2: fl = PCT_W'($urandom_range(PCT_FULL + 1, 127));
			default: fl = PCT_W'($urandom_range(0, 60));
		endcase
		case ($urandom_range(0, 7))
			0: win = '0;
			1: win = 5'd1;
			2: win = WIN_CFG_W'(WINDOW_MAX);
			3: win = WIN_CFG_W'($urandom_range(WINDOW_MAX + 1, 31));
			default: win = WIN_CFG_W'($urandom_range(2, WINDOW_MAX - 1));
		endcase
		configure(en, a, b, fl, win);
	endtask

	function automatic logic [SAMPLE_BITS-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return range_low;
			3: return range_high;
			4: return range_low - 1'b1;
			5: return range_high + 1'b1;
			6, 7: return SAMPLE_BITS'($urandom);
			default: return SAMPLE_BITS'($urandom_range(range_high, range_low));
		endcase
	endfunction

	initial begin
		int sent;
		int phase_no;
		int phase_len;
		bit quiet;
		arst_n = 1'b0;
		in_valid = 1'b0;
		sensor_sample = '0;
		cfg_write = 1'b0;
		cfg_index = REG_ENABLE;
		cfg_data = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults after reset: disabled
		send_sample('0);
		send_sample(16'hFFFF);
		send_sample(16'd2047);
		settle();

		// full range, no smoothing
		configure(1'b1, '0, 16'hFFFF, '0, 5'd1);
		send_sample('0);
		send_sample(16'hFFFF);
		send_sample(16'd32767);
		send_sample(16'd32768);
		send_sample(16'd1);
		send_sample(16'h5555);
		send_sample(16'hAAAA);
		settle();

		// empty range, floor above full, window zero
		configure(1'b1, 16'd1000, 16'd1000, 7'd127, 5'd0);
		send_sample(16'd1000);
		send_sample('0);
		settle();

		// tiny span with rounding halves, window above the maximum
		configure(1'b1, 16'd100, 16'd102, '0, 5'd31);
		send_sample(16'd99);
		send_sample(16'd101);
		send_sample(16'd103);
		send_sample(16'd100);
		send_sample(16'd102);
		send_sample(16'd101);
		send_sample(16'hFFFF);
		send_sample(16'd100);
		send_sample('0);
		send_sample(16'd101);
		settle();

		// window shrinks below the history held
		configure(1'b1, 16'd100, 16'd102, 7'd50, 5'd3);
		send_sample(16'd102);
		send_sample(16'd100);
		send_sample(16'd101);

		sent = 0;
		phase_no = 0;
		while (sent < RANDOM_ITEMS) begin
			settle();
			choose_setting();
			phase_len = $urandom_range(20, 60);
			quiet = (sent >= RANDOM_ITEMS - QUIET_ITEMS);
			tx_gaps = !quiet && ($urandom_range(0, 2) != 0);
			rx_gaps = !quiet && ($urandom_range(0, 2) != 0);
			if (phase_no == 2) begin
				tx_gaps = 1'b0;
				hold_request = 1'b1;
			end
			repeat (phase_len) begin
				send_sample(pick_sample());
				sent++;
			end
			phase_no++;
		end

		settle();
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
